// ===== rtl/core/dtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtf_pkg;

    localparam int VALUE_W      = 64;
    localparam int INT_W        = 31;
    localparam int FRAC_ACC_W   = 30;
    localparam int FCOUNT_W     = 4;
    localparam int FRAC_DIGITS  = 9;
    localparam int FRAC_BITS_DEF = 32;
    localparam int CMD_DEPTH    = 2;
    localparam int CMD_PTR_W    = 1;
    localparam int CMD_CNT_W    = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

    // One finished string, waiting for the fraction division.
    typedef struct packed {
        logic                  negative;
        logic [INT_W-1:0]      int_acc;
        logic                  int_sat;
        logic [FRAC_ACC_W-1:0] frac_acc;
        logic [FCOUNT_W-1:0]   frac_count;
        logic                  frac_dropped;
    } cmd_t;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FCOUNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        begin
            unique case (n)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                default: p = 30'd1000000000;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  ch,
    input  wire logic        cmd_full,
    output dtf_pkg::cmd_t    cmd,
    output logic             cmd_push
);

    dtf_pkg::phase_t                   phase_reg, phase_next;
    logic                              negative_reg, negative_next;
    logic [dtf_pkg::INT_W-1:0]         int_acc_reg, int_acc_next;
    logic                              int_sat_reg, int_sat_next;
    logic [dtf_pkg::FRAC_ACC_W-1:0]    frac_acc_reg, frac_acc_next;
    logic [dtf_pkg::FCOUNT_W-1:0]      frac_count_reg, frac_count_next;
    logic                              frac_dropped_reg, frac_dropped_next;

    logic                              accept;
    logic                              is_nul;
    logic                              is_digit;
    logic                              is_space;
    logic [3:0]                        digit;
    logic [dtf_pkg::INT_W+3:0]         int_prod;
    logic [dtf_pkg::FRAC_ACC_W-1:0]    frac_prod;

    assign accept   = push && !cmd_full;
    assign is_nul   = (ch == dtf_pkg::CH_NUL);
    assign is_digit = (ch >= dtf_pkg::CH_ZERO) && (ch <= dtf_pkg::CH_NINE);
    assign is_space = (ch == dtf_pkg::CH_SPACE) ||
                      ((ch >= dtf_pkg::CH_TAB) && (ch <= dtf_pkg::CH_CR));
    assign digit    = ch[3:0];

    // Times ten as two shifts and an add.
    assign int_prod = ({4'b0, int_acc_reg} << 3) + ({4'b0, int_acc_reg} << 1)
                    + {{dtf_pkg::INT_W{1'b0}}, digit};
    assign frac_prod = (frac_acc_reg << 3) + (frac_acc_reg << 1)
                     + {{(dtf_pkg::FRAC_ACC_W-4){1'b0}}, digit};

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (is_nul)
            begin
                phase_next = dtf_pkg::PH_SKIP;
            end
            else
            begin
                unique case (phase_reg)
                    dtf_pkg::PH_SKIP:
                    begin
                        if (is_space)
                            phase_next = dtf_pkg::PH_SKIP;
                        else if (ch == dtf_pkg::CH_MINUS || is_digit)
                            phase_next = dtf_pkg::PH_INT;
                        else
                            phase_next = dtf_pkg::PH_FRAC;
                    end
                    dtf_pkg::PH_INT:
                    begin
                        if (!is_digit)
                            phase_next = dtf_pkg::PH_FRAC;
                    end
                    dtf_pkg::PH_FRAC:
                    begin
                        if (!is_digit)
                            phase_next = dtf_pkg::PH_DONE;
                    end
                    default:
                    begin
                        phase_next = dtf_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        negative_next     = negative_reg;
        int_acc_next      = int_acc_reg;
        int_sat_next      = int_sat_reg;
        frac_acc_next     = frac_acc_reg;
        frac_count_next   = frac_count_reg;
        frac_dropped_next = frac_dropped_reg;
        if (accept)
        begin
            if (is_nul)
            begin
                negative_next     = 1'b0;
                int_acc_next      = '0;
                int_sat_next      = 1'b0;
                frac_acc_next     = '0;
                frac_count_next   = '0;
                frac_dropped_next = 1'b0;
            end
            else if ((phase_reg == dtf_pkg::PH_SKIP || phase_reg == dtf_pkg::PH_INT)
                     && is_digit)
            begin
                if (int_prod > {4'b0, dtf_pkg::INT_MAX})
                begin
                    int_acc_next = dtf_pkg::INT_MAX;
                    int_sat_next = 1'b1;
                end
                else
                begin
                    int_acc_next = int_prod[dtf_pkg::INT_W-1:0];
                end
            end
            else if (phase_reg == dtf_pkg::PH_SKIP && ch == dtf_pkg::CH_MINUS)
            begin
                negative_next = 1'b1;
            end
            else if (phase_reg == dtf_pkg::PH_FRAC && is_digit)
            begin
                if (frac_count_reg < dtf_pkg::FCOUNT_W'(dtf_pkg::FRAC_DIGITS))
                begin
                    frac_acc_next   = frac_prod;
                    frac_count_next = frac_count_reg + 4'd1;
                end
                else
                begin
                    frac_dropped_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        cmd_push         = accept && is_nul;
        cmd.negative     = negative_reg;
        cmd.int_acc      = int_acc_reg;
        cmd.int_sat      = int_sat_reg;
        cmd.frac_acc     = frac_acc_reg;
        cmd.frac_count   = frac_count_reg;
        cmd.frac_dropped = frac_dropped_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= dtf_pkg::PH_SKIP;
            negative_reg     <= 1'b0;
            int_acc_reg      <= '0;
            int_sat_reg      <= 1'b0;
            frac_acc_reg     <= '0;
            frac_count_reg   <= '0;
            frac_dropped_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            int_acc_reg      <= int_acc_next;
            int_sat_reg      <= int_sat_next;
            frac_acc_reg     <= frac_acc_next;
            frac_count_reg   <= frac_count_next;
            frac_dropped_reg <= frac_dropped_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dtf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire dtf_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output dtf_pkg::cmd_t      rd_data,
    output logic               empty
);

    dtf_pkg::cmd_t                    mem [dtf_pkg::CMD_DEPTH];
    logic [dtf_pkg::CMD_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dtf_pkg::CMD_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dtf_pkg::CMD_CNT_W-1:0]    count_reg, count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full    = (count_reg == dtf_pkg::CMD_CNT_W'(dtf_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dtf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_back #(
    parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dtf_pkg::cmd_t               cmd,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic                        pop,
    output logic                             empty,
    output logic signed [dtf_pkg::VALUE_W-1:0] value,
    output logic                             int_overflow,
    output logic                             digits_dropped
);

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int PAD_W = dtf_pkg::VALUE_W - dtf_pkg::INT_W - FRAC_BITS;

    dtf_pkg::back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             neg_reg;
    logic [dtf_pkg::INT_W-1:0]        int_reg;
    logic                             sat_reg;
    logic                             drop_reg;
    logic [dtf_pkg::FRAC_ACC_W-1:0]   div_reg;
    logic [dtf_pkg::FRAC_ACC_W-1:0]   rem_reg, rem_next;
    logic [FRAC_BITS-1:0]             quo_reg, quo_next;
    logic                             out_valid_reg, out_valid_next;
    logic [dtf_pkg::VALUE_W-1:0]      value_reg;
    logic                             ovf_reg;
    logic                             drp_reg;

    logic                             load;
    logic                             out_write;
    logic [dtf_pkg::FRAC_ACC_W:0]     rem_shift;
    logic [dtf_pkg::FRAC_ACC_W:0]     rem_diff;
    logic                             q_bit;
    logic [dtf_pkg::VALUE_W-1:0]      mag;

    // Restoring division: the remainder stays below the divisor, one quotient bit a cycle.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign q_bit     = (rem_shift >= {1'b0, div_reg});
    assign mag       = {{PAD_W{1'b0}}, int_reg, quo_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtf_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                    state_next = dtf_pkg::BK_DIV;
            end
            dtf_pkg::BK_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = dtf_pkg::BK_OUT;
            end
            dtf_pkg::BK_OUT:
            begin
                if (!out_valid_reg || pop)
                    state_next = dtf_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = dtf_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load      = (state_reg == dtf_pkg::BK_IDLE) && !cmd_empty;
        cmd_pop   = load;
        out_write = (state_reg == dtf_pkg::BK_OUT) && (!out_valid_reg || pop);

        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            cnt_next = CNT_W'(FRAC_BITS - 1);
            rem_next = cmd.frac_acc;
            quo_next = '0;
        end
        else if (state_reg == dtf_pkg::BK_DIV)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = q_bit ? rem_diff[dtf_pkg::FRAC_ACC_W-1:0]
                             : rem_shift[dtf_pkg::FRAC_ACC_W-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], q_bit};
        end

        out_valid_next = out_valid_reg;
        if (out_write)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= cmd.negative;
            int_reg  <= cmd.int_acc;
            sat_reg  <= cmd.int_sat;
            drop_reg <= cmd.frac_dropped;
            div_reg  <= dtf_pkg::pow10(cmd.frac_count);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (out_write)
        begin
            value_reg <= neg_reg ? (~mag + 1'b1) : mag;
            ovf_reg   <= sat_reg;
            drp_reg   <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtf_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty          = !out_valid_reg;
    assign value          = value_reg;
    assign int_overflow   = ovf_reg;
    assign digits_dropped = drp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// input     ch[7:0]                                 push / full
// result    value[63:0], int_overflow, digits_dropped  empty / pop
//
// The parser takes a new character whenever push is high and full is low. A NUL closes
// the string and hands it to a two-entry queue; the back end then divides the fraction
// by 10^n with one quotient bit per cycle. full rises only when both queue entries wait
// on the back end; reset clears the parser, the queue counters and the back-end state,
// and the parser returns to skipping whitespace.

module decimal_text_to_fixed_point #(
    parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     ch,
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [dtf_pkg::VALUE_W-1:0]  value,
    output logic                                int_overflow,
    output logic                                digits_dropped
);

    dtf_pkg::cmd_t  front_cmd;
    dtf_pkg::cmd_t  back_cmd;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_full;
    logic           cmd_empty;

    assign full = cmd_full;

    dtf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .ch       (ch),
        .cmd_full (cmd_full),
        .cmd      (front_cmd),
        .cmd_push (cmd_push)
    );

    dtf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    dtf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (back_cmd),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .pop            (pop),
        .empty          (empty),
        .value          (value),
        .int_overflow   (int_overflow),
        .digits_dropped (digits_dropped)
    );

endmodule

`default_nettype wire
